// ===== hdl/amcf_pkg.sv =====
// ----------------------------------------------------------------------------
// amcf_pkg: shared types, codes and helpers for the AVI movi chunk finder
// Holds the scan phase and status codes, register indexes, the RIFF list
// identifiers and the helper that builds a chunk id from a stream number.
// ----------------------------------------------------------------------------
package amcf_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_OVERRUN = 2'd1,
        ST_END     = 2'd2
    } t_status;

    localparam logic [1:0] CFG_STREAM_NUMBER = 2'd0;
    localparam logic [1:0] CFG_VIDEO_SELECT  = 2'd1;
    localparam logic [1:0] CFG_REGION_LENGTH = 2'd2;

    // Little-endian four-character codes.
    localparam logic [31:0] FCC_LIST = 32'h5453_494C;
    localparam logic [31:0] FCC_RIFF = 32'h4646_4952;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_W    = 8'h77;
    localparam logic [7:0] CH_B    = 8'h62;

    typedef struct packed {
        logic [31:0] region_length;
        logic [31:0] id_a;
        logic [31:0] id_b;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_size;
    } t_result;

    // Chunk id from the two low decimal digits of n, tens digit first.
    // n / 10 is taken as (n * 205) >> 11, exact for every 8-bit n.
    function automatic logic [31:0] make_id(input logic [7:0] n,
                                            input logic [7:0] c2,
                                            input logic [7:0] c3);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [4:0]  tens;
        logic [7:0]  ones;
        prod = {8'd0, n} * 16'd205;
        q    = prod[15:11];
        ones = n - 8'({3'd0, q} * 8'd10);
        if (q >= 5'd20) begin
            tens = q - 5'd20;
        end else if (q >= 5'd10) begin
            tens = q - 5'd10;
        end else begin
            tens = q;
        end
        return {c3, c2, CH_ZERO + ones, CH_ZERO + {3'd0, tens}};
    endfunction

endpackage

// ===== hdl/amcf_cfg.sv =====
// ----------------------------------------------------------------------------
// amcf_cfg: configuration registers of the chunk finder
// Stores stream number, video select and region length, and derives the two
// chunk ids that the scanner compares against.
// ----------------------------------------------------------------------------
module amcf_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output amcf_pkg::t_cfg   o_cfg
);
    import amcf_pkg::*;

    logic [7:0]  r_stream_number;
    logic        r_video_select;
    logic [31:0] r_region_length;
    logic [31:0] id_dc;
    logic [31:0] id_db;
    logic [31:0] id_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_number <= 8'd0;
            r_video_select  <= 1'b1;
            r_region_length <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STREAM_NUMBER: r_stream_number <= i_cfg_data[7:0];
                CFG_VIDEO_SELECT:  r_video_select  <= i_cfg_data[0];
                CFG_REGION_LENGTH: r_region_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        id_dc = make_id(r_stream_number, CH_D, CH_C);
        id_db = make_id(r_stream_number, CH_D, CH_B);
        id_wb = make_id(r_stream_number, CH_W, CH_B);
        o_cfg.region_length = r_region_length;
        // Audio has a single id, so both compare slots carry it.
        o_cfg.id_a = r_video_select ? id_dc : id_wb;
        o_cfg.id_b = r_video_select ? id_db : id_wb;
    end

endmodule

// ===== hdl/amcf_scan.sv =====
// ----------------------------------------------------------------------------
// amcf_scan: chunk header scanner
// Holds the byte position, header shift register, header byte count, skip
// counter and scan phase, and works out the result of one byte per step.
// ----------------------------------------------------------------------------
module amcf_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_restart,
    input  amcf_pkg::t_cfg    i_cfg,
    output amcf_pkg::t_result o_res
);
    import amcf_pkg::*;

    logic [32:0] r_pos;
    logic [55:0] r_shift;
    logic [2:0]  r_count;
    logic [32:0] r_skip;
    t_phase      r_phase;

    logic [32:0] n_pos;
    logic [55:0] n_shift;
    logic [2:0]  n_count;
    logic [32:0] n_skip;
    t_phase      n_phase;

    // State as seen by this byte, after a restart has been applied.
    logic [32:0] e_pos;
    logic [2:0]  e_count;
    logic [32:0] e_skip;
    t_phase      e_phase;

    logic [32:0] pos1;
    logic [2:0]  count1;
    logic [32:0] skip_dec;
    logic [63:0] full;
    logic [31:0] id;
    logic [31:0] size;
    logic [32:0] padded;
    logic [33:0] data_end;
    logic        bound_now;
    logic        bound_next;
    logic        overrun;
    logic        is_match;
    logic        is_list;

    always_comb begin
        e_pos      = i_restart ? 33'd0 : r_pos;
        e_count    = i_restart ? 3'd0 : r_count;
        e_skip     = i_restart ? 33'd0 : r_skip;
        e_phase    = i_restart ? PH_HEADER : r_phase;
        pos1       = e_pos + 33'd1;
        count1     = e_count + 3'd1;
        skip_dec   = (e_skip != 33'd0) ? e_skip - 33'd1 : e_skip;
        full       = {i_data_byte, r_shift};
        id         = full[31:0];
        size       = full[63:32];
        padded     = {1'b0, size} + {32'd0, size[0]};
        data_end   = {1'b0, pos1} + {1'b0, padded};
        bound_now  = ({1'b0, e_pos} + 34'd8) > {2'b00, i_cfg.region_length};
        bound_next = ({1'b0, pos1} + 34'd8) > {2'b00, i_cfg.region_length};
        overrun    = data_end > ({2'b00, i_cfg.region_length} + 34'd1);
        is_match   = ((id == i_cfg.id_a) || (id == i_cfg.id_b)) && (size != 32'd0);
        is_list    = ((id == FCC_LIST) || (id == FCC_RIFF)) && (size >= 32'd4);
    end

    // Next state.
    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        n_count = r_count;
        n_skip  = r_skip;
        n_phase = r_phase;
        if (i_step) begin
            n_pos   = e_pos;
            n_count = e_count;
            n_skip  = e_skip;
            n_phase = e_phase;
            case (e_phase)
                PH_HEADER: begin
                    if ((e_count == 3'd0) && bound_now) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_pos   = pos1;
                        n_shift = full[63:8];
                        n_count = count1;
                        if (count1 == 3'd0) begin
                            if (overrun) begin
                                n_phase = PH_DONE;
                            end else if (is_match) begin
                                n_skip  = padded;
                                n_phase = PH_SKIP;
                            end else if (is_list) begin
                                n_skip  = 33'd4;
                                n_phase = PH_SKIP;
                            end else if (padded != 33'd0) begin
                                n_skip  = padded;
                                n_phase = PH_SKIP;
                            end else begin
                                n_skip  = padded;
                                n_phase = bound_next ? PH_DONE : PH_HEADER;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_pos  = pos1;
                    n_skip = skip_dec;
                    if (skip_dec == 33'd0) begin
                        n_count = 3'd0;
                        n_phase = bound_next ? PH_DONE : PH_HEADER;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result of this byte.
    always_comb begin
        o_res.valid        = 1'b0;
        o_res.status       = ST_MATCH;
        o_res.chunk_offset = 32'd0;
        o_res.chunk_size   = 32'd0;
        case (e_phase)
            PH_HEADER: begin
                if ((e_count == 3'd0) && bound_now) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_END;
                end else if (count1 == 3'd0) begin
                    if (overrun) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_OVERRUN;
                    end else if (is_match) begin
                        o_res.valid        = 1'b1;
                        o_res.status       = ST_MATCH;
                        o_res.chunk_offset = pos1[31:0];
                        o_res.chunk_size   = size;
                    end else if (!is_list && (padded == 33'd0) && bound_next) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_END;
                    end
                end
            end
            PH_SKIP: begin
                if ((skip_dec == 33'd0) && bound_next) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_END;
                end
            end
            default: ;
        endcase
        o_res.valid = o_res.valid && i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 33'd0;
            r_count <= 3'd0;
            r_skip  <= 33'd0;
            r_phase <= PH_HEADER;
        end else begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_skip  <= n_skip;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_DONE) && !i_restart) |=> (r_phase == PH_DONE))
        else $error("scan left the stopped phase without a restart");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 33'd0))
        else $error("skip phase with an empty skip counter");

    a_count_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 3'd0) |-> (r_phase == PH_HEADER))
        else $error("partial header outside the header phase");

    a_match_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_MATCH)) |=> (r_phase == PH_SKIP))
        else $error("matching chunk not followed by a data skip");

endmodule

// ===== hdl/avi_movi_stream_chunk_finder_unit.sv =====
// ----------------------------------------------------------------------------
// avi_movi_stream_chunk_finder_unit: AVI movi stream chunk finder
// Scans the bytes of an AVI movi region, reports each chunk of the selected
// stream with its data offset and size, and flags overruns and region end.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_data_byte, i_restart
//   result    out        o_out_valid / i_out_ready  o_status, o_chunk_offset,
//                                                   o_chunk_size
//   config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// The block takes one byte item per clock cycle unless a held result stalls it.
// An accepted item waits in the input register and is scanned from it once the
// output register can take a result, which, if there is one, is registered there.
// The cycle of work is set by the header compare and the 34-bit end-of-data
// adder in the scanner. Reset is synchronous and active low; it returns the
// configuration to its defaults and the scan to the start of a header.
// A stalled result holds the output register; the input register keeps
// taking bytes until it is full, and flows again as soon as the result moves.
//
// A byte with the restart flag set begins a new region at offset zero. After
// an overrun or the region end is reported, bytes are dropped until a restart.
// Results carry offset and size only for a matching chunk, and zero otherwise.
// ----------------------------------------------------------------------------
module avi_movi_stream_chunk_finder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_chunk_offset,
    output logic [31:0] o_chunk_size,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import amcf_pkg::*;

    // Input register: one byte item waiting to be scanned.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_restart;

    // Output register: one result item waiting to be taken.
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_chunk_offset;
    logic [31:0] r_chunk_size;

    t_cfg        cfg;
    t_result     res;
    logic        step;

    // The scanner advances whenever a byte is held and the output register
    // either is empty or is being emptied in this cycle.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    amcf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    amcf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_restart   (r_in_restart),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_status       <= res.status;
            r_chunk_offset <= res.chunk_offset;
            r_chunk_size   <= res.chunk_size;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_chunk_offset = r_chunk_offset;
    assign o_chunk_size   = r_chunk_size;

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_chunk_offset)))
        else $error("waiting result was lost or changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status != 2'd3))
        else $error("result carries an undefined status");

    a_result_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result produced without a byte in the input register");

endmodule

// ===== tb/amcf_chunk_checker.sv =====
// ----------------------------------------------------------------------------
// amcf_chunk_checker: result checker for the AVI movi chunk finder
// Watches the byte, result and register channels, runs its own scan of the
// region for every accepted byte and compares each result with the oldest
// one still due.
// ----------------------------------------------------------------------------
module amcf_chunk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_chunk_offset,
    input  logic [31:0] i_chunk_size,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_backlog,
    output int          o_hits,
    output int          o_overruns,
    output int          o_ends
);
    import amcf_pkg::*;

    // Register copies.
    logic [7:0]  cfg_stream;
    logic        cfg_video;
    logic [31:0] cfg_region;

    // Scan state.
    logic [32:0] pos;
    logic [63:0] hdr;
    logic [2:0]  hdr_cnt;
    logic [32:0] skip_cnt;
    t_phase      phase;

    t_result     due_q[$];

    function automatic logic [31:0] wanted_id(input logic [7:0] n, input logic [7:0] c2,
                                              input logic [7:0] c3);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = (n / 8'd10) % 8'd10;
        ones = n % 8'd10;
        return {c3, c2, CH_ZERO + ones, CH_ZERO + tens};
    endfunction

    // Stops the scan with a region end when no further header fits.
    function automatic t_result header_room_check();
        t_result r;
        r = '0;
        if ({1'b0, pos} + 34'd8 > {2'b0, cfg_region}) begin
            phase    = PH_DONE;
            r.valid  = 1'b1;
            r.status = ST_END;
        end
        return r;
    endfunction

    function automatic t_result scan_byte(input logic [7:0] b, input logic rs);
        t_result     r;
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] want_a;
        logic [31:0] want_b;
        logic [32:0] span;
        logic [34:0] data_end;
        r = '0;
        if (rs) begin
            pos      = '0;
            hdr      = '0;
            hdr_cnt  = '0;
            skip_cnt = '0;
            phase    = PH_HEADER;
        end
        if (phase == PH_HEADER && hdr_cnt == 3'd0) begin
            r = header_room_check();
            if (r.valid) return r;
        end
        if (phase != PH_HEADER && phase != PH_SKIP) return r;

        pos = pos + 33'd1;

        if (phase == PH_SKIP) begin
            if (skip_cnt != '0) skip_cnt = skip_cnt - 33'd1;
            if (skip_cnt == '0) begin
                phase   = PH_HEADER;
                hdr_cnt = '0;
                return header_room_check();
            end
            return r;
        end

        hdr     = {b, hdr[63:8]};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt != 3'd0) return r;

        id       = hdr[31:0];
        size     = hdr[63:32];
        span     = {1'b0, size} + {32'd0, size[0]};
        data_end = {2'b0, pos} + {2'b0, span};
        if (data_end > {3'b0, cfg_region} + 35'd1) begin
            phase    = PH_DONE;
            r.valid  = 1'b1;
            r.status = ST_OVERRUN;
            return r;
        end

        want_a = cfg_video ? wanted_id(cfg_stream, CH_D, CH_C)
                           : wanted_id(cfg_stream, CH_W, CH_B);
        want_b = cfg_video ? wanted_id(cfg_stream, CH_D, CH_B) : want_a;
        if ((id == want_a || id == want_b) && size != '0) begin
            skip_cnt       = span;
            phase          = PH_SKIP;
            r.valid        = 1'b1;
            r.status       = ST_MATCH;
            r.chunk_offset = pos[31:0];
            r.chunk_size   = size;
            return r;
        end

        // Lists only drop their type word; the children are scanned in place.
        if ((id == FCC_LIST || id == FCC_RIFF) && size >= 32'd4) begin
            skip_cnt = 33'd4;
        end else begin
            skip_cnt = span;
        end
        if (skip_cnt == '0) return header_room_check();
        phase = PH_SKIP;
        return r;
    endfunction

    task automatic note_failure(input string what, input t_result want, input t_result seen);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("chunk checker: %s: expected status %0d offset %0d size %0d,",
                     what, want.status, want.chunk_offset, want.chunk_size);
            $display("    got status %0d offset %0d size %0d",
                     seen.status, seen.chunk_offset, seen.chunk_size);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            cfg_stream   = 8'd0;
            cfg_video    = 1'b1;
            cfg_region   = 32'd0;
            pos          = '0;
            hdr          = '0;
            hdr_cnt      = '0;
            skip_cnt     = '0;
            phase        = PH_HEADER;
            o_mismatches = 0;
            o_hits       = 0;
            o_overruns   = 0;
            o_ends       = 0;
            due_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STREAM_NUMBER: cfg_stream = i_cfg_data[7:0];
                    CFG_VIDEO_SELECT:  cfg_video  = i_cfg_data[0];
                    CFG_REGION_LENGTH: cfg_region = i_cfg_data;
                    default: ;
                endcase
            end
            // Results leave before new bytes are scanned, so a result can never be
            // paired with the byte accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                seen              = '0;
                seen.valid        = 1'b1;
                seen.status       = t_status'(i_status);
                seen.chunk_offset = i_chunk_offset;
                seen.chunk_size   = i_chunk_size;
                case (seen.status)
                    ST_MATCH:   o_hits++;
                    ST_OVERRUN: o_overruns++;
                    default:    o_ends++;
                endcase
                if (due_q.size() == 0) begin
                    note_failure("result with none due", '0, seen);
                end else begin
                    want = due_q.pop_front();
                    if (want.status != seen.status || want.chunk_offset != seen.chunk_offset
                            || want.chunk_size != seen.chunk_size) begin
                        note_failure("wrong result", want, seen);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = scan_byte(i_data_byte, i_restart);
                if (want.valid) due_q.push_back(want);
            end
        end
        o_backlog <= due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the AVI movi stream chunk finder
// Builds AVI movi regions out of RIFF chunks, programs the stream and region
// registers for each, streams the bytes with random gaps and back-pressure
// and leaves all checking to the chunk checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import amcf_pkg::*;

    // Stop when about this many byte items have gone in.
    localparam int ITEM_TARGET   = 1600;
    // Quiet cycles waited after the last due result has come out, before
    // registers are touched or the verdict is given.
    localparam int SETTLE_CYCLES = 4;
    // The longest quiet stretch of a correct run is the receiver hold below
    // plus a drain; random gaps at 19 percent are almost always far shorter.
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_START    = 1200;
    localparam int HOLD_CYCLES   = 300;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = 8'd0;
    logic        restart      = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [1:0]  status;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_size;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_index    = 2'd0;
    logic [31:0] cfg_data     = 32'd0;

    int          mismatches;
    int          backlog;
    int          hits;
    int          overruns;
    int          ends;

    // Stimulus bookkeeping, owned by the stimulus process.
    logic [7:0]  region_bytes[$];
    logic [7:0]  cur_stream;
    logic        cur_video;
    int          items_sent   = 0;
    int          regions_done = 0;
    int          reg_writes   = 0;
    int          quiet_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    avi_movi_stream_chunk_finder_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_restart      (restart),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_chunk_offset (chunk_offset),
        .o_chunk_size   (chunk_size),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    amcf_chunk_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_restart      (restart),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_status       (status),
        .i_chunk_offset (chunk_offset),
        .i_chunk_size   (chunk_size),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_backlog      (backlog),
        .o_hits         (hits),
        .o_overruns     (overruns),
        .o_ends         (ends)
    );

    // Offers one byte item and returns at the edge where it is accepted. The
    // sender idles now and then before an item, except in a stretch early in
    // the run where bytes go back to back.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        while (!(items_sent >= 300 && items_sent < 650) && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        restart   <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Drops valid, waits until every result due has come out, then lets the
    // pipeline empty so that registers can be written safely.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register; the caller lowers the write enable after a group.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        reg_writes++;
    endtask

    // Chunk header words are little endian, first character in the low byte.
    task automatic push_word(input logic [31:0] w);
        region_bytes.push_back(w[7:0]);
        region_bytes.push_back(w[15:8]);
        region_bytes.push_back(w[23:16]);
        region_bytes.push_back(w[31:24]);
    endtask

    // A chunk with a huge size only gets a few bytes of body; the scan either
    // overruns on it or skips past the end of what is sent.
    task automatic push_chunk(input logic [31:0] id, input logic [31:0] size);
        push_word(id);
        push_word(size);
        if (size <= 32'd400) begin
            repeat (size + {31'd0, size[0]}) region_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 6)) region_bytes.push_back(8'($urandom));
        end
    endtask

    function automatic logic [31:0] pick_chunk_size();
        int p;
        p = $urandom_range(99);
        if (p < 8) return 32'd0;
        if (p < 78) return $urandom_range(1, 24);
        if (p < 92) return $urandom_range(25, 160);
        case ($urandom_range(3))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'hFFFF_FFFE;
            2:       return 32'h8000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_stream();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd99;
            3:       return 8'd100;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly the exact region size, with edges just around it and the
    // register extremes now and then.
    function automatic logic [31:0] pick_region_length(input int n);
        int p;
        p = $urandom_range(99);
        if (p < 55) return 32'(n);
        if (p < 65) return 32'(n + 1);
        if (p < 72) return 32'(n - 1);
        if (p < 80) return $urandom_range(0, n);
        if (p < 86) return 32'(n + $urandom_range(2, 20));
        if (p < 90) return 32'd0;
        if (p < 95) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Builds one region for the current stream: mostly well-formed chunks
    // (wanted ids, near misses, lists and junk), sometimes plain noise.
    task automatic build_region();
        int          p;
        logic [7:0]  tens;
        logic [7:0]  ones;
        logic [7:0]  suffix;
        logic [31:0] size;
        tens = CH_ZERO + 8'((cur_stream / 10) % 10);
        ones = CH_ZERO + 8'(cur_stream % 10);
        region_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(8, 48)) region_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                p      = $urandom_range(99);
                size   = pick_chunk_size();
                suffix = $urandom_range(1) ? CH_C : CH_B;
                if (p < 40) begin
                    if (cur_video) begin
                        push_chunk({suffix, CH_D, ones, tens}, size);
                    end else begin
                        push_chunk({CH_B, CH_W, ones, tens}, size);
                    end
                end else if (p < 52) begin
                    // Right stream, wrong kind of data.
                    if (cur_video) begin
                        push_chunk({CH_B, CH_W, ones, tens}, size);
                    end else begin
                        push_chunk({suffix, CH_D, ones, tens}, size);
                    end
                end else if (p < 62) begin
                    push_chunk({CH_C, CH_D, CH_ZERO + 8'($urandom_range(9)),
                                CH_ZERO + 8'($urandom_range(9))}, size);
                end else if (p < 82) begin
                    if ($urandom_range(9) < 8) begin
                        // A list header and its type word; the following
                        // chunks become its children.
                        push_word($urandom_range(1) ? FCC_LIST : FCC_RIFF);
                        push_word($urandom_range(4, 60));
                        repeat (4) region_bytes.push_back(8'($urandom));
                    end else begin
                        push_chunk($urandom_range(1) ? FCC_LIST : FCC_RIFF,
                                   $urandom_range(0, 3));
                    end
                end else begin
                    push_chunk($urandom, size);
                end
            end
        end
    endtask

    // One register setting and one region. Some regions are cut short, get a
    // register change partway through, a restart in the middle or trailing
    // bytes after their end.
    task automatic run_region();
        int n;
        int idx;
        int split_at;
        int restart_at;
        cur_stream = pick_stream();
        cur_video  = 1'($urandom_range(1));
        build_region();
        n = region_bytes.size();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, n - 1)) void'(region_bytes.pop_back());
        end
        settle();
        write_reg(CFG_STREAM_NUMBER, {24'd0, cur_stream});
        write_reg(CFG_VIDEO_SELECT, {31'd0, cur_video});
        write_reg(CFG_REGION_LENGTH, pick_region_length(n));
        cfg_we <= 1'b0;

        split_at   = -1;
        restart_at = -1;
        if (region_bytes.size() > 1) begin
            if ($urandom_range(99) < 15) split_at = $urandom_range(1, region_bytes.size() - 1);
            if ($urandom_range(99) < 6) restart_at = $urandom_range(1, region_bytes.size() - 1);
        end
        for (idx = 0; idx < region_bytes.size(); idx++) begin
            if (idx == split_at) begin
                // The scan carries on without a restart under the new values.
                settle();
                write_reg(CFG_REGION_LENGTH, pick_region_length(n));
                if ($urandom_range(1)) write_reg(CFG_STREAM_NUMBER, {24'd0, pick_stream()});
                if ($urandom_range(2) == 0) write_reg(CFG_VIDEO_SELECT, $urandom_range(1));
                cfg_we <= 1'b0;
            end
            send_byte(region_bytes[idx], (idx == 0) || (idx == restart_at));
        end
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        end
        regions_done++;
    endtask

    // Receiver: drops ready at random, keeps it high through one stretch and
    // holds it low once for a long time so that the block backs up into its
    // input while bytes are still being offered.
    initial begin : receiver
        int rx_cycle;
        rx_cycle = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycle += HOLD_CYCLES;
            end
            if (rx_cycle >= 400 && rx_cycle < 800) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 19);
            end
        end
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Straight after reset the region length is zero: the first byte,
        // even without a restart, reports the region end, and so does a
        // restart on the stopped scan.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Stream 255 uses the digits 55. A 3-byte video chunk with its pad
        // byte, then a chunk whose size only overruns when the data end is
        // summed without wrap, then one byte that the stopped scan ignores.
        settle();
        write_reg(CFG_STREAM_NUMBER, 32'd255);
        write_reg(CFG_VIDEO_SELECT, 32'd1);
        write_reg(CFG_REGION_LENGTH, 32'd28);
        cfg_we <= 1'b0;
        region_bytes.delete();
        push_word({CH_B, CH_D, CH_ZERO + 8'd5, CH_ZERO + 8'd5});
        push_word(32'd3);
        region_bytes.push_back(8'h00);
        region_bytes.push_back(8'hFF);
        region_bytes.push_back(8'h5A);
        region_bytes.push_back(8'hA5);
        push_word(32'h1234_5678);
        push_word(32'hFFFF_FFFF);
        foreach (region_bytes[i]) send_byte(region_bytes[i], i == 0);
        send_byte(8'h80, 1'b0);

        while (items_sent < ITEM_TARGET) run_region();

        settle();
        $display("Sent %0d byte items in %0d regions with %0d register writes.",
                 items_sent, regions_done, reg_writes);
        $display("Checked %0d chunk hits, %0d overruns and %0d region ends.",
                 hits, overruns, ends);
        if (mismatches == 0 && backlog == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/amcf_pkg.sv
hdl/amcf_cfg.sv
hdl/amcf_scan.sv
hdl/avi_movi_stream_chunk_finder_unit.sv
tb/amcf_chunk_checker.sv
tb/tb.sv
